### hdl/transformed_vertex_aabb_macros.svh
// Assertion macros for the transformed-vertex bounding box block.
// Used by the checker; expects clk_i and rst_ni in the enclosing scope.
`ifndef TRANSFORMED_VERTEX_AABB_MACROS_SVH
`define TRANSFORMED_VERTEX_AABB_MACROS_SVH
// Same-cycle implication.
`define TVA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tva assertion failed");
// Next-cycle implication.
`define TVA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tva assertion failed");
`endif

### hdl/tva_pkg.sv
// Shared package of the transformed-vertex bounding box block.
// Widths, register indexes and reset values, component codes, control structs.
package tva_pkg;

  // Default sizes
  localparam int COORD_BITS_DEF = 16;
  localparam int BOX_BITS_DEF   = 24;

  // Configuration port
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;
  localparam int COMP_W    = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_POSITION = 3'd4;

  localparam logic [CFG_W-1:0] AXIS_X_RST   = 48'h0000_0000_4000;
  localparam logic [CFG_W-1:0] AXIS_Y_RST   = 48'h0000_4000_0000;
  localparam logic [CFG_W-1:0] AXIS_Z_RST   = 48'h4000_0000_0000;
  localparam logic [CFG_W-1:0] SCALE_RST    = 48'h0100_0100_0100;
  localparam logic [CFG_W-1:0] POSITION_RST = 48'h0000_0000_0000;

  // Component codes
  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic       load_vtx;
    logic       scale;
    logic       mul;
    logic       acc;
    logic [1:0] comp;
    logic       emit;
  } tva_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;
    logic out_busy;
  } tva_sts_t;

  // Pick one signed 16-bit component out of a packed x,y,z register
  function automatic logic signed [COMP_W-1:0] sel_comp(input logic [CFG_W-1:0] v,
                                                        input logic [1:0] c);
    logic signed [COMP_W-1:0] r;
    case (c)
      COMP_X:  r = v[15:0];
      COMP_Y:  r = v[31:16];
      COMP_Z:  r = v[47:32];
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### hdl/tva_vtx_if.sv
// Vertex input channel and bounding box output channel interfaces.
// Depends on nothing; widths come from parameters.
interface tva_vtx_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic signed [COORD_BITS-1:0] vertex_z;
  logic                         mesh_start;
  logic                         last_vertex;

  modport source (output valid, vertex_x, vertex_y, vertex_z, mesh_start, last_vertex,
                  input ready);
  modport sink (input valid, vertex_x, vertex_y, vertex_z, mesh_start, last_vertex,
                output ready);
endinterface

interface tva_box_if #(
  parameter int BOX_BITS = 24
);
  logic                       valid;
  logic                       ready;
  logic signed [BOX_BITS-1:0] box_min_x;
  logic signed [BOX_BITS-1:0] box_min_y;
  logic signed [BOX_BITS-1:0] box_min_z;
  logic signed [BOX_BITS-1:0] box_max_x;
  logic signed [BOX_BITS-1:0] box_max_y;
  logic signed [BOX_BITS-1:0] box_max_z;

  modport source (output valid, box_min_x, box_min_y, box_min_z,
                  box_max_x, box_max_y, box_max_z, input ready);
  modport sink (input valid, box_min_x, box_min_y, box_min_z,
                box_max_x, box_max_y, box_max_z, output ready);
endinterface

### hdl/tva_ctrl.sv
// Sequencer of the bounding box block: steps one vertex through scale,
// per-component rotate and accumulate, then box emission after a last vertex. Uses tva_pkg.
module tva_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tva_pkg::tva_sts_t sts_i,
  output tva_pkg::tva_cmd_t cmd_o
);
  import tva_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCALE = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_ACC   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0] state_q, state_d;
  logic [1:0] comp_q, comp_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    comp_d     = comp_q;
    cmd_o      = '0;
    cmd_o.comp = comp_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_vtx = 1'b1;
          state_d        = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        comp_d      = COMP_X;
        state_d     = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        if (comp_q == COMP_Z) begin
          state_d = sts_i.last ? ST_OUT : ST_IDLE;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = ST_MUL;
        end
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      comp_q  <= COMP_X;
    end else begin
      state_q <= state_d;
      comp_q  <= comp_d;
    end
  end

endmodule

### hdl/tva_datapath.sv
// Datapath of the bounding box block: config registers, scale and rotate
// multipliers, rounding, saturation, running min/max, output register. Uses tva_pkg.
module tva_datapath #(
  parameter int COORD_BITS = tva_pkg::COORD_BITS_DEF,
  parameter int BOX_BITS   = tva_pkg::BOX_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [tva_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tva_pkg::CFG_W-1:0]           cfg_data_i,
  // vertex payload
  input  logic signed [COORD_BITS-1:0]        vertex_x_i,
  input  logic signed [COORD_BITS-1:0]        vertex_y_i,
  input  logic signed [COORD_BITS-1:0]        vertex_z_i,
  input  logic                                mesh_start_i,
  input  logic                                last_vertex_i,
  // box output
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [BOX_BITS-1:0]          box_min_o [3],
  output logic signed [BOX_BITS-1:0]          box_max_o [3],
  // control
  input  tva_pkg::tva_cmd_t                   cmd_i,
  output tva_pkg::tva_sts_t                   sts_o
);
  import tva_pkg::*;

  localparam int SCL_W = COORD_BITS + COMP_W;       // scaled vertex, Q.16
  localparam int PRD_W = SCL_W + COMP_W;            // rotated term, Q.30
  localparam int SUM_W = PRD_W + 2;                 // sum of three terms
  localparam int RND_W = SUM_W - 22;                // back to Q.8
  localparam int EXT_W = (RND_W > BOX_BITS) ? RND_W : BOX_BITS;
  localparam int POS_W = BOX_BITS + 1;
  localparam longint BoxHiL = (longint'(1) <<< (BOX_BITS - 1)) - 1;
  localparam logic signed [EXT_W-1:0] BOX_HI = EXT_W'(BoxHiL);
  localparam logic signed [EXT_W-1:0] BOX_LO = EXT_W'(-BoxHiL - 1);
  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(longint'(1) <<< 21);

  // Configuration registers
  logic [CFG_W-1:0] axis_x_q, axis_y_q, axis_z_q, scale_q, position_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_x_q   <= AXIS_X_RST;
      axis_y_q   <= AXIS_Y_RST;
      axis_z_q   <= AXIS_Z_RST;
      scale_q    <= SCALE_RST;
      position_q <= POSITION_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_AXIS_X:   axis_x_q   <= cfg_data_i;
        CFG_AXIS_Y:   axis_y_q   <= cfg_data_i;
        CFG_AXIS_Z:   axis_z_q   <= cfg_data_i;
        CFG_SCALE:    scale_q    <= cfg_data_i;
        CFG_POSITION: position_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Vertex capture
  logic signed [COORD_BITS-1:0] vtx_q [3];
  logic                         first_q, last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_vtx) begin
      vtx_q[0] <= vertex_x_i;
      vtx_q[1] <= vertex_y_i;
      vtx_q[2] <= vertex_z_i;
      first_q  <= mesh_start_i;
      last_q   <= last_vertex_i;
    end
  end

  // Per-component scale, three multipliers
  logic signed [SCL_W-1:0] scl_q [3];

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      for (int k = 0; k < 3; k++) begin
        scl_q[k] <= SCL_W'(vtx_q[k]) * SCL_W'(sel_comp(scale_q, 2'(k)));
      end
    end
  end

  // Rotation terms for world component cmd_i.comp
  logic signed [COMP_W-1:0] ax_c, ay_c, az_c;
  logic signed [PRD_W-1:0]  prd_q [3];

  assign ax_c = sel_comp(axis_x_q, cmd_i.comp);
  assign ay_c = sel_comp(axis_y_q, cmd_i.comp);
  assign az_c = sel_comp(axis_z_q, cmd_i.comp);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prd_q[0] <= PRD_W'(scl_q[0]) * PRD_W'(ax_c);
      prd_q[1] <= PRD_W'(scl_q[1]) * PRD_W'(ay_c);
      prd_q[2] <= PRD_W'(scl_q[2]) * PRD_W'(az_c);
    end
  end

  // Sum, round half up, saturate
  logic signed [SUM_W-1:0]    sum;
  logic signed [RND_W-1:0]    rnd;
  logic signed [EXT_W-1:0]    rnd_ext;
  logic signed [BOX_BITS-1:0] world;

  always_comb begin
    sum     = SUM_W'(prd_q[0]) + SUM_W'(prd_q[1]) + SUM_W'(prd_q[2]) + RND_HALF;
    rnd     = sum[SUM_W-1:22];
    rnd_ext = EXT_W'(rnd);
    if (rnd_ext > BOX_HI) begin
      world = BOX_BITS'(BOX_HI);
    end else if (rnd_ext < BOX_LO) begin
      world = BOX_BITS'(BOX_LO);
    end else begin
      world = BOX_BITS'(rnd_ext);
    end
  end

  // Running box; a vertex with the first mark seeds it
  logic signed [BOX_BITS-1:0] min_q [3];
  logic signed [BOX_BITS-1:0] max_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        min_q[k] <= '0;
        max_q[k] <= '0;
      end
    end else if (cmd_i.acc) begin
      if (first_q || world < min_q[cmd_i.comp]) min_q[cmd_i.comp] <= world;
      if (first_q || world > max_q[cmd_i.comp]) max_q[cmd_i.comp] <= world;
    end
  end

  // Position offset with saturation
  logic signed [BOX_BITS-1:0] omin_d [3];
  logic signed [BOX_BITS-1:0] omax_d [3];

  always_comb begin
    logic signed [POS_W-1:0] pos, smin, smax;
    for (int k = 0; k < 3; k++) begin
      pos  = POS_W'(sel_comp(position_q, 2'(k)));
      smin = POS_W'(min_q[k]) + pos;
      smax = POS_W'(max_q[k]) + pos;
      if (smin[POS_W-1] != smin[POS_W-2]) begin
        omin_d[k] = {smin[POS_W-1], {(BOX_BITS-1){~smin[POS_W-1]}}};
      end else begin
        omin_d[k] = smin[BOX_BITS-1:0];
      end
      if (smax[POS_W-1] != smax[POS_W-2]) begin
        omax_d[k] = {smax[POS_W-1], {(BOX_BITS-1){~smax[POS_W-1]}}};
      end else begin
        omax_d[k] = smax[BOX_BITS-1:0];
      end
    end
  end

  // Output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      box_min_o <= omin_d;
      box_max_o <= omax_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.last     = last_q;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

endmodule

### hdl/transformed_vertex_aabb.sv
// Top level of the transformed-vertex bounding box block.
// Depends on tva_pkg, tva_vtx_if/tva_box_if, tva_ctrl and tva_datapath.
// Usage:
//  - vtx_i takes one vertex item (x, y, z in signed Q.8, first/last marks)
//    when valid and ready are both high. Each vertex is scaled, rotated by
//    the three axis registers, rounded to Q.8, saturated, and folded into a
//    running per-axis min/max. A first mark seeds the box.
//  - After a vertex with the last mark, box_o carries one item: both corners
//    plus the position register, saturated to BOX_BITS signed.
//  - Timing: a vertex steps through accept, scale, then a multiply and an
//    accumulate step for each of three world components; scale and rotate
//    use separate sets of three multipliers. A last vertex adds a step to
//    load the output register, which waits while that register is busy.
//    ready is high only while the sequencer is idle.
//  - The output register holds a finished box while the sink stalls; the
//    next mesh is accepted meanwhile, and a new box waits in the sequencer
//    until the register is free.
//  - Reset clears the running box to zero and loads identity axes, unit
//    scale and zero position. The box is kept after emission.
//  - cfg_we_i writes register cfg_idx_i; indexes beyond four are ignored.
module transformed_vertex_aabb #(
  parameter int COORD_BITS = tva_pkg::COORD_BITS_DEF,
  parameter int BOX_BITS   = tva_pkg::BOX_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tva_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tva_pkg::CFG_W-1:0]     cfg_data_i,
  tva_vtx_if.sink                       vtx_i,
  tva_box_if.source                     box_o
);
  import tva_pkg::*;

  tva_cmd_t cmd;
  tva_sts_t sts;
  logic signed [BOX_BITS-1:0] box_min [3];
  logic signed [BOX_BITS-1:0] box_max [3];

  tva_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (vtx_i.valid),
    .in_ready_o (vtx_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tva_datapath #(
    .COORD_BITS (COORD_BITS),
    .BOX_BITS   (BOX_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .vertex_x_i     (vtx_i.vertex_x),
    .vertex_y_i     (vtx_i.vertex_y),
    .vertex_z_i     (vtx_i.vertex_z),
    .mesh_start_i   (vtx_i.mesh_start),
    .last_vertex_i  (vtx_i.last_vertex),
    .out_valid_o    (box_o.valid),
    .out_ready_i    (box_o.ready),
    .box_min_o      (box_min),
    .box_max_o      (box_max),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

  assign box_o.box_min_x = box_min[0];
  assign box_o.box_min_y = box_min[1];
  assign box_o.box_min_z = box_min[2];
  assign box_o.box_max_x = box_max[0];
  assign box_o.box_max_y = box_max[1];
  assign box_o.box_max_z = box_max[2];

endmodule

### hdl/tva_checker.sv
// Port-level checker of the bounding box block, bound to the top level.
// Depends on transformed_vertex_aabb_macros.svh.
`include "transformed_vertex_aabb_macros.svh"

module tva_checker #(
  parameter int BOX_BITS = tva_pkg::BOX_BITS_DEF
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [BOX_BITS-1:0] out_min_x_i,
  input logic [BOX_BITS-1:0] out_max_z_i
);

  // one vertex at a time: ready drops after an accepted item
  `TVA_ASSERT_NEXT(a_one_at_a_time, in_valid_i && in_ready_i, !in_ready_i)
  // a box never appears right after a vertex is taken
  `TVA_ASSERT_NEXT(a_no_early_box, in_valid_i && in_ready_i, !$rose(out_valid_i))
  // stalled box stays offered
  `TVA_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  // stalled box keeps its corners
  `TVA_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i, $stable(out_min_x_i) && $stable(out_max_z_i))

endmodule

bind transformed_vertex_aabb tva_checker #(
  .BOX_BITS (BOX_BITS)
) u_tva_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (vtx_i.valid),
  .in_ready_i  (vtx_i.ready),
  .out_valid_i (box_o.valid),
  .out_ready_i (box_o.ready),
  .out_min_x_i (box_o.box_min_x),
  .out_max_z_i (box_o.box_max_z)
);

### tb/sv/tva_box_checker.sv
// Checker for the transformed-vertex bounding box block: watches the config port
// and both channels, predicts each box and compares it with the one sent out.
// Depends on tva_pkg and the tva_vtx_if / tva_box_if interfaces.
module tva_box_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tva_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tva_pkg::CFG_W-1:0]     cfg_data_i,
  tva_vtx_if                            vtx_i,
  tva_box_if                            box_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import tva_pkg::*;

  localparam int BOX_BITS   = BOX_BITS_DEF;
  localparam int MAX_REPORT = 10;

  typedef logic signed [BOX_BITS-1:0] coord_t;
  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } box_t;

  // Shadow copies of the registers and the running box
  logic [CFG_W-1:0] axis_x_r, axis_y_r, axis_z_r, scale_r, position_r;
  coord_t           run_min [3];
  coord_t           run_max [3];
  box_t             box_expected_q [$];
  int               fail_count = 0;

  // Signed 16-bit component c of a packed x,y,z register
  function automatic longint comp_of(input logic [CFG_W-1:0] regv, input int c);
    logic signed [COMP_W-1:0] v;
    v = regv[c*COMP_W +: COMP_W];
    return longint'(v);
  endfunction

  function automatic coord_t clamp_box(input longint x);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (BOX_BITS - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return coord_t'(hi);
    if (x < lo) return coord_t'(lo);
    return coord_t'(x);
  endfunction

  // World component c: exact Q.30 sum, rounded half up to Q.8, clamped
  function automatic coord_t world_axis(input int c, input longint sx, input longint sy,
                                        input longint sz);
    longint acc;
    acc = sx * comp_of(axis_x_r, c) + sy * comp_of(axis_y_r, c) + sz * comp_of(axis_z_r, c);
    return clamp_box((acc + (longint'(1) <<< 21)) >>> 22);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    longint scaled [3];
    coord_t world [3];
    box_t   want;
    box_t   got;
    if (!rst_ni) begin
      axis_x_r   <= AXIS_X_RST;
      axis_y_r   <= AXIS_Y_RST;
      axis_z_r   <= AXIS_Z_RST;
      scale_r    <= SCALE_RST;
      position_r <= POSITION_RST;
      for (int c = 0; c < 3; c++) begin
        run_min[c] = '0;
        run_max[c] = '0;
      end
      box_expected_q.delete();
      pending_o <= 0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_AXIS_X:   axis_x_r   <= cfg_data_i;
          CFG_AXIS_Y:   axis_y_r   <= cfg_data_i;
          CFG_AXIS_Z:   axis_z_r   <= cfg_data_i;
          CFG_SCALE:    scale_r    <= cfg_data_i;
          CFG_POSITION: position_r <= cfg_data_i;
          default: ;
        endcase
      end

      // outgoing box against the oldest expectation
      if (box_i.valid && box_i.ready) begin
        got = '{box_i.box_min_x, box_i.box_min_y, box_i.box_min_z,
                box_i.box_max_x, box_i.box_max_y, box_i.box_max_z};
        if (box_expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORT)
            $display("%0t: box with none expected: min (%0d %0d %0d) max (%0d %0d %0d)",
                     $realtime, got.min_x, got.min_y, got.min_z,
                     got.max_x, got.max_y, got.max_z);
        end else begin
          want = box_expected_q.pop_front();
          if (got.min_x !== want.min_x || got.min_y !== want.min_y ||
              got.min_z !== want.min_z || got.max_x !== want.max_x ||
              got.max_y !== want.max_y || got.max_z !== want.max_z) begin
            fail_count++;
            if (fail_count <= MAX_REPORT)
              $display("%0t: box mismatch: expected min (%0d %0d %0d) max (%0d %0d %0d), %s",
                       $realtime, want.min_x, want.min_y, want.min_z,
                       want.max_x, want.max_y, want.max_z,
                       $sformatf("got min (%0d %0d %0d) max (%0d %0d %0d)",
                                 got.min_x, got.min_y, got.min_z,
                                 got.max_x, got.max_y, got.max_z));
          end
        end
      end

      // incoming vertex: scale, rotate, fold into the running box
      if (vtx_i.valid && vtx_i.ready) begin
        scaled[0] = longint'(vtx_i.vertex_x) * comp_of(scale_r, 0);
        scaled[1] = longint'(vtx_i.vertex_y) * comp_of(scale_r, 1);
        scaled[2] = longint'(vtx_i.vertex_z) * comp_of(scale_r, 2);
        for (int c = 0; c < 3; c++) begin
          world[c] = world_axis(c, scaled[0], scaled[1], scaled[2]);
          if (vtx_i.mesh_start) begin
            run_min[c] = world[c];
            run_max[c] = world[c];
          end else begin
            if (world[c] < run_min[c]) run_min[c] = world[c];
            if (world[c] > run_max[c]) run_max[c] = world[c];
          end
        end
        if (vtx_i.last_vertex) begin
          want.min_x = clamp_box(longint'(run_min[0]) + comp_of(position_r, 0));
          want.min_y = clamp_box(longint'(run_min[1]) + comp_of(position_r, 1));
          want.min_z = clamp_box(longint'(run_min[2]) + comp_of(position_r, 2));
          want.max_x = clamp_box(longint'(run_max[0]) + comp_of(position_r, 0));
          want.max_y = clamp_box(longint'(run_max[1]) + comp_of(position_r, 1));
          want.max_z = clamp_box(longint'(run_max[2]) + comp_of(position_r, 2));
          box_expected_q.push_back(want);
        end
      end
      pending_o <= box_expected_q.size();
    end
  end

  assign fail_count_o = fail_count;

endmodule

### tb/sv/tb_top.sv
// Testbench top for transformed_vertex_aabb: clock, reset, config writes and
// vertex stimulus; the checker tva_box_checker predicts and compares the boxes.
// Depends on tva_pkg, tva_vtx_if, tva_box_if, the block and the checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tva_pkg::*;

  localparam int          COORD_BITS   = COORD_BITS_DEF;
  localparam int          BOX_BITS     = BOX_BITS_DEF;
  localparam int          PHASES       = 10;
  localparam int          PHASE_ITEMS  = 125;
  localparam int          SETTLE_TICKS = 16;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int          STRAY_LO     = CFG_POSITION + 1;
  localparam int          STRAY_HI     = (1 << CFG_IDX_W) - 1;

  logic                 clk_i  = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  int                   fail_count;
  int                   pending;
  int                   send_idle_pct;
  int                   sink_stall_pct;
  int unsigned          cycles = 0;

  tva_vtx_if #(.COORD_BITS(COORD_BITS)) vtx_ch ();
  tva_box_if #(.BOX_BITS(BOX_BITS))     box_ch ();

  always #4 clk_i = ~clk_i;

  transformed_vertex_aabb #(
    .COORD_BITS(COORD_BITS),
    .BOX_BITS  (BOX_BITS)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .vtx_i     (vtx_ch),
    .box_o     (box_ch)
  );

  tva_box_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .vtx_i       (vtx_ch),
    .box_i       (box_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Box receiver stalls at random
  always @(posedge clk_i) begin
    box_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [COORD_BITS-1:0] pick_coord();
    case ($urandom_range(9))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return '0;
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [COMP_W-1:0] pick_wild_comp();
    case ($urandom_range(7))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return '0;
      3:       return 16'h4000;
      4:       return 16'hc000;
      default: return COMP_W'($urandom);
    endcase
  endfunction

  // One vertex item; holds valid until accepted
  task automatic send_vertex(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                             input logic [COORD_BITS-1:0] z, input logic fst,
                             input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      vtx_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    vtx_ch.valid       <= 1'b1;
    vtx_ch.vertex_x    <= x;
    vtx_ch.vertex_y    <= y;
    vtx_ch.vertex_z    <= z;
    vtx_ch.mesh_start  <= fst;
    vtx_ch.last_vertex <= lst;
    @(posedge clk_i);
    while (!vtx_ch.ready) @(posedge clk_i);
  endtask

  // Wait until every expected box is out and the sequencer has gone quiet
  task automatic drain();
    vtx_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic load_setting(input logic [CFG_W-1:0] ax, input logic [CFG_W-1:0] ay,
                              input logic [CFG_W-1:0] az, input logic [CFG_W-1:0] sc,
                              input logic [CFG_W-1:0] pos, input bit stray);
    write_reg(CFG_AXIS_X, ax);
    write_reg(CFG_AXIS_Y, ay);
    write_reg(CFG_AXIS_Z, az);
    write_reg(CFG_SCALE, sc);
    write_reg(CFG_POSITION, pos);
    // unused index must leave every register alone
    if (stray)
      write_reg(CFG_IDX_W'($urandom_range(STRAY_HI, STRAY_LO)), CFG_W'({$urandom, $urandom}));
    cfg_we_i <= 1'b0;
  endtask

  // Wild settings hit extremes and saturate; tame ones stay mostly in range
  task automatic random_setting(input bit wild);
    logic [CFG_W-1:0] regs [5];
    int               t;
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (wild)
          regs[r][c*COMP_W +: COMP_W] = pick_wild_comp();
        else begin
          if (r < 3) t = int'($urandom_range(32768)) - 16384;
          else if (r == 3) t = int'($urandom_range(2048)) - 1024;
          else t = $urandom;
          regs[r][c*COMP_W +: COMP_W] = t[COMP_W-1:0];
        end
      end
    end
    load_setting(regs[0], regs[1], regs[2], regs[3], regs[4], 1'($urandom_range(1)));
  endtask

  // Mostly well-formed meshes, some with a missing mark, plus stray vertices
  task automatic run_meshes(input int n_items);
    int  sent;
    int  len;
    bit  drop_first;
    bit  drop_last;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        send_vertex(pick_coord(), pick_coord(), pick_coord(),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
        sent++;
      end else begin
        len        = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(6, 1);
        drop_first = ($urandom_range(15) == 0);
        drop_last  = ($urandom_range(15) == 0);
        for (int i = 0; i < len; i++)
          send_vertex(pick_coord(), pick_coord(), pick_coord(),
                      (i == 0) && !drop_first, (i == len - 1) && !drop_last);
        sent += len;
      end
    end
  endtask

  initial begin
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_AXIS_X;
    cfg_data_i         = '0;
    vtx_ch.valid       = 1'b0;
    vtx_ch.vertex_x    = '0;
    vtx_ch.vertex_y    = '0;
    vtx_ch.vertex_z    = '0;
    vtx_ch.mesh_start  = 1'b0;
    vtx_ch.last_vertex = 1'b0;
    send_idle_pct      = 0;
    sink_stall_pct     = 0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: open box with no first mark, single-vertex meshes,
    // a box kept after emission and then extended
    send_vertex(16'd5, -16'sd3, 16'd7, 1'b0, 1'b1);
    send_vertex(16'h7fff, 16'h8000, 16'h0000, 1'b1, 1'b1);
    send_vertex(16'h8000, 16'h7fff, 16'hffff, 1'b1, 1'b0);
    send_vertex(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_vertex(16'h7fff, 16'h8000, 16'h0001, 1'b0, 1'b1);
    send_vertex(16'd100, -16'sd100, 16'd50, 1'b0, 1'b1);
    send_vertex(-16'sd256, 16'd256, 16'hffff, 1'b1, 1'b0);
    send_vertex(16'h0001, 16'hffff, 16'h7fff, 1'b0, 1'b1);
    drain();

    // Full-scale axes and scale: rotated vertices clamp at both ends
    load_setting(48'h7fff_7fff_7fff, 48'h7fff_8000_7fff, 48'h8000_7fff_7fff,
                 48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff, 1'b0);
    send_vertex(16'h7fff, 16'h7fff, 16'h7fff, 1'b1, 1'b1);
    send_vertex(16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b1);
    send_vertex(16'h7fff, 16'h8000, 16'h7fff, 1'b1, 1'b0);
    send_vertex(16'h0000, 16'h0001, 16'hffff, 1'b0, 1'b0);
    send_vertex(16'h8000, 16'h7fff, 16'h8000, 1'b0, 1'b1);
    drain();

    // Most negative scale and axes: corners land on the box limits and the
    // negative position pushes the minimum past the lower limit
    load_setting(48'h0000_0000_8000, 48'h0000_8000_0000, 48'h8000_0000_0000,
                 48'h8000_8000_8000, 48'h8000_8000_8000, 1'b1);
    send_vertex(16'h7fff, 16'h7fff, 16'h7fff, 1'b1, 1'b1);
    send_vertex(16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b1);
    send_vertex(16'h0001, 16'hffff, 16'h0000, 1'b1, 1'b0);
    send_vertex(16'h8000, 16'h7fff, 16'h0000, 1'b0, 1'b1);
    drain();

    // Random meshes under changing settings and idling
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin send_idle_pct = 78; sink_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  sink_stall_pct = 78; end
        default: begin send_idle_pct = 21; sink_stall_pct = 21; end
      endcase
      random_setting(ph % 2);
      run_meshes(PHASE_ITEMS);
      drain();
    end

    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
